// ===== hw/rtl/isotp_pkg.sv =====
// ----------------------------------------------------------------------------
// ISO-TP reassembler package
// Shared types and codes for the frame reassembler blocks.
// ----------------------------------------------------------------------------
package isotp_pkg;

    localparam int unsigned FRAME_BYTES = 8;
    localparam int unsigned MAX_OUT     = 7;

    localparam logic [3:0] KIND_SINGLE = 4'd0;
    localparam logic [3:0] KIND_FIRST  = 4'd1;
    localparam logic [3:0] KIND_CONSEC = 4'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_TYPE = 2'd1;
    localparam logic [1:0] ST_SHORT    = 2'd2;

    typedef struct packed {
        logic [FRAME_BYTES-1:0][7:0] data;
        logic                        starts_response;
        logic                        ends_response;
    } frame_t;

    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] data;
        logic [2:0]              count;
        logic                    fin;
        logic [1:0]              fin_status;
    } desc_t;

endpackage

// ===== hw/rtl/isotp_decode.sv =====
// ----------------------------------------------------------------------------
// ISO-TP frame decoder
// Classifies one frame, tracks the open message and describes its output.
// ----------------------------------------------------------------------------
module isotp_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  isotp_pkg::frame_t     frame,
    input  logic                  consume,
    output isotp_pkg::desc_t      desc
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COLLECT
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [11:0] total_reg;
    logic [11:0] total_next;
    logic [11:0] emitted_reg;
    logic [11:0] emitted_next;

    logic [3:0]  kind;
    logic [3:0]  nib;
    logic [11:0] first_total;
    logic [11:0] remain;
    logic [11:0] sum;

    always_comb
    begin
        kind        = frame.data[0][7:4];
        nib         = frame.data[0][3:0];
        first_total = {nib, frame.data[1]};
        remain      = total_reg - emitted_reg;
        sum         = 12'd0;

        phase_next      = phase_reg;
        total_next      = total_reg;
        emitted_next    = emitted_reg;
        desc.count      = 3'd0;
        desc.fin        = 1'b0;
        desc.fin_status = isotp_pkg::ST_OK;
        for (int i = 0; i < int'(isotp_pkg::MAX_OUT); i++)
        begin
            desc.data[i] = frame.data[i + 1];
        end

        if (frame.starts_response)
        begin
            phase_next = PH_IDLE;
            if (kind == isotp_pkg::KIND_SINGLE)
            begin
                desc.count = (nib > 4'd7) ? 3'd7 : nib[2:0];
                desc.fin   = 1'b1;
            end
            else if (kind == isotp_pkg::KIND_FIRST)
            begin
                for (int i = 0; i < int'(isotp_pkg::MAX_OUT) - 1; i++)
                begin
                    desc.data[i] = frame.data[i + 2];
                end
                desc.data[isotp_pkg::MAX_OUT-1] = 8'd0;
                desc.count   = (first_total < 12'd6) ? first_total[2:0] : 3'd6;
                total_next   = first_total;
                emitted_next = {9'd0, desc.count};
                if (emitted_next >= first_total)
                begin
                    desc.fin = 1'b1;
                end
                else if (frame.ends_response)
                begin
                    desc.fin        = 1'b1;
                    desc.fin_status = isotp_pkg::ST_SHORT;
                end
                else
                begin
                    phase_next = PH_COLLECT;
                end
            end
            else
            begin
                desc.fin        = 1'b1;
                desc.fin_status = isotp_pkg::ST_BAD_TYPE;
            end
        end
        else if (phase_reg == PH_COLLECT)
        begin
            if (kind == isotp_pkg::KIND_CONSEC)
            begin
                desc.count   = (remain < 12'd7) ? remain[2:0] : 3'd7;
                sum          = emitted_reg + {9'd0, desc.count};
                emitted_next = sum;
                if (sum >= total_reg)
                begin
                    desc.fin   = 1'b1;
                    phase_next = PH_IDLE;
                end
                else if (frame.ends_response)
                begin
                    desc.fin        = 1'b1;
                    desc.fin_status = isotp_pkg::ST_SHORT;
                    phase_next      = PH_IDLE;
                end
            end
            else if (frame.ends_response)
            begin
                desc.fin        = 1'b1;
                desc.fin_status = isotp_pkg::ST_SHORT;
                phase_next      = PH_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            total_reg   <= 12'd0;
            emitted_reg <= 12'd0;
        end
        else if (consume)
        begin
            phase_reg   <= phase_next;
            total_reg   <= total_next;
            emitted_reg <= emitted_next;
        end
    end

endmodule

// ===== hw/rtl/isotp_emit.sv =====
// ----------------------------------------------------------------------------
// ISO-TP byte emitter
// Holds one frame description; emits its results one per cycle unless stalled.
// ----------------------------------------------------------------------------
module isotp_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_valid,
    input  isotp_pkg::desc_t  desc,
    output logic              load_ready,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        data_byte,
    output logic              byte_valid,
    output logic              last_in_message,
    output logic [1:0]        status
);

    logic             active_reg;
    isotp_pkg::desc_t desc_reg;
    logic [2:0]       idx_reg;
    logic [2:0]       total;
    logic             last_beat;
    logic             has_results;

    assign total       = desc_reg.count +
                         {2'd0, (desc_reg.fin && (desc_reg.count == 3'd0))};
    assign last_beat   = (idx_reg == total - 3'd1);
    assign load_ready  = !active_reg || (!out_stall && last_beat);
    assign has_results = (desc.count != 3'd0) || desc.fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= 3'd0;
        end
        else if (load_ready)
        begin
            active_reg <= load_valid && has_results;
            idx_reg    <= 3'd0;
        end
        else if (!out_stall)
        begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
        begin
            desc_reg <= desc;
        end
    end

    always_comb
    begin
        out_valid       = active_reg;
        byte_valid      = (idx_reg < desc_reg.count);
        data_byte       = byte_valid ? desc_reg.data[idx_reg] : 8'd0;
        last_in_message = desc_reg.fin && last_beat;
        status          = last_in_message ? desc_reg.fin_status : isotp_pkg::ST_OK;
    end

endmodule

// ===== hw/rtl/isotp_frame_reassembler.sv =====
// ----------------------------------------------------------------------------
// ISO-TP frame reassembler
// Rebuilds a message's payload bytes from single, first and consecutive frames.
// ----------------------------------------------------------------------------
// Each accepted frame is held in an input register, decoded combinationally
// and handed to the emitter, which delivers its result items one per cycle
// while out_stall is low: a frame yields at most seven result items, and a
// frame that yields none is consumed without occupying the emitter. The next
// frame is taken into the input register while the emitter still works, and
// the emitter takes its description with the current frame's last item.
// Consecutive-frame sequence numbers are not checked.
module isotp_frame_reassembler (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] frame_byte0,
    input  logic [7:0] frame_byte1,
    input  logic [7:0] frame_byte2,
    input  logic [7:0] frame_byte3,
    input  logic [7:0] frame_byte4,
    input  logic [7:0] frame_byte5,
    input  logic [7:0] frame_byte6,
    input  logic [7:0] frame_byte7,
    input  logic       starts_response,
    input  logic       ends_response,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] data_byte,
    output logic       byte_valid,
    output logic       last_in_message,
    output logic [1:0] status
);

    logic              in_valid_reg;
    isotp_pkg::frame_t frame_reg;
    isotp_pkg::desc_t  desc;
    logic              load_ready;
    logic              consume;
    logic              accept;

    assign consume  = in_valid_reg && load_ready;
    assign in_stall = in_valid_reg && !load_ready;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frame_reg.data            <= {frame_byte7, frame_byte6, frame_byte5, frame_byte4,
                                          frame_byte3, frame_byte2, frame_byte1, frame_byte0};
            frame_reg.starts_response <= starts_response;
            frame_reg.ends_response   <= ends_response;
        end
    end

    isotp_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .frame   (frame_reg),
        .consume (consume),
        .desc    (desc)
    );

    isotp_emit u_emit (
        .clk             (clk),
        .rst_n           (rst_n),
        .load_valid      (in_valid_reg),
        .desc            (desc),
        .load_ready      (load_ready),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .data_byte       (data_byte),
        .byte_valid      (byte_valid),
        .last_in_message (last_in_message),
        .status          (status)
    );

endmodule

// ===== hw/rtl/isotp_checker.sv =====
// ----------------------------------------------------------------------------
// ISO-TP reassembler checker
// Port-level properties of the reassembler's result stream.
// ----------------------------------------------------------------------------
module isotp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] data_byte,
    input logic       byte_valid,
    input logic       last_in_message,
    input logic [1:0] status
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(status)
        && $stable(last_in_message))
        else $error("stalled result item changed");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> data_byte == 8'd0 && last_in_message)
        else $error("bare end marker is not a zero final item");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != isotp_pkg::ST_OK |-> last_in_message)
        else $error("error status on a non-final item");

    a_bad_type: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == isotp_pkg::ST_BAD_TYPE |-> !byte_valid)
        else $error("bad frame type reported with payload");

endmodule

bind isotp_frame_reassembler isotp_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .data_byte       (data_byte),
    .byte_valid      (byte_valid),
    .last_in_message (last_in_message),
    .status          (status)
);
